// ===== rtl/bbsf_pkg.sv =====
// Shared widths, operation codes and the result item type of the byte stream FIFO.
package bbsf_pkg;

   localparam int BYTE_W = 8;
   localparam int MODE_W = 3;
   localparam int RUN_W  = 7;
   localparam int CNT_W  = 9;
   localparam int TOT_W  = 64;

   // longest peek, pop or read run; longer requests saturate here
   localparam logic [RUN_W-1:0] MAX_RUN = 7'd64;

   localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

   localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_END   = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic              last;
      logic              accepted;
      logic              error_flag;
      logic              ended;
      logic              at_eof;
      logic [CNT_W-1:0]  occupancy;
      logic [CNT_W-1:0]  free_space;
      logic [TOT_W-1:0]  total_written;
      logic [TOT_W-1:0]  total_read;
   } rsp_item_type;

endpackage

// ===== rtl/bbsf_ifs.sv =====
// Request and response channel interfaces of the byte stream FIFO.
interface bbsf_req_if;
   import bbsf_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [BYTE_W-1:0] data_byte;
   logic [RUN_W-1:0]  run_length;

   modport source (output valid, output mode, output data_byte, output run_length,
                   input ready);
   modport sink   (input valid, input mode, input data_byte, input run_length,
                   output ready);
endinterface

interface bbsf_rsp_if;
   import bbsf_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              has_byte;
   logic              last;
   logic              accepted;
   logic              error_flag;
   logic              ended;
   logic              at_eof;
   logic [CNT_W-1:0]  occupancy;
   logic [CNT_W-1:0]  free_space;
   logic [TOT_W-1:0]  total_written;
   logic [TOT_W-1:0]  total_read;

   modport source (output valid, output out_byte, output has_byte, output last,
                   output accepted, output error_flag, output ended, output at_eof,
                   output occupancy, output free_space, output total_written,
                   output total_read, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input last,
                   input accepted, input error_flag, input ended, input at_eof,
                   input occupancy, input free_space, input total_written,
                   input total_read, output ready);
endinterface

// ===== rtl/bbsf_rsp_queue.sv =====
// Two-entry result queue that decouples the FIFO core from response back-pressure.
module bbsf_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bbsf_pkg::rsp_item_type push_item,
   input  logic                  pop,
   output logic                  out_valid,
   output bbsf_pkg::rsp_item_type out_item,
   output logic [1:0]            count
);
   import bbsf_pkg::*;

   rsp_item_type ent0_ff, ent0_in;
   rsp_item_type ent1_ff, ent1_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      ent0_in  = ent0_ff;
      ent1_in  = ent1_ff;
      count_in = count_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               ent0_in  = push_item;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            case ({push, pop})
               2'b10: begin
                  ent1_in  = push_item;
                  count_in = 2'd2;
               end
               2'b01: count_in = 2'd0;
               2'b11: ent0_in = push_item;
               default: ;
            endcase
         end
         default: begin
            if (pop) begin
               ent0_in = ent1_ff;
               if (push) begin
                  ent1_in = push_item;
               end else begin
                  count_in = 2'd1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_item  = ent0_ff;
   assign count     = count_ff;

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == 2'd2) |-> pop)
      else $error("result queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1 && pop && !push) |=> count_ff == 2'd0)
      else $error("result queue did not drain");

endmodule

// ===== rtl/bounded_byte_stream_fifo_unit.sv =====
// Top level of the bounded byte stream FIFO with peek, pop and read operations.
//
//  channel  | dir | handshake         | item
//  ---------+-----+-------------------+---------------------------------------------
//  req_ch   | in  | valid/ready       | mode, data_byte, run_length
//  rsp_ch   | out | valid/ready       | out_byte, has_byte, last, status, totals
//  csr      | in  | csr_we            | csr_wdata = stream_capacity (resets to 256)
//
// Order: write, pop, end, failed or empty ops stream back to back while a queue slot is
//   free; a peek or read of k bytes returns one byte per cycle while a queue slot is free,
//   set by the single read port of the byte store (accept, then one read per byte).
// Reset: synchronous; clears pointers, counts, flags and totals. The byte store is
//   not cleared: only held bytes are ever read back, so no clearing pass is needed.
// Stalls: results go through a two-entry queue; a store read or a new item is issued
//   only when a queue slot is guaranteed, so the core never stalls mid-pipeline.
module bounded_byte_stream_fifo_unit #(
   parameter int DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   bbsf_req_if.sink                      req_ch,
   bbsf_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  logic [bbsf_pkg::CNT_W-1:0]    csr_wdata
);
   import bbsf_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW   = ((AW > CNT_W) ? AW : CNT_W) + 1;
   // occupancy can never pass the register range or the store depth
   localparam int CMAX = (1 << CNT_W) - 1;
   localparam int DCAP = (DEPTH > CMAX) ? CMAX : DEPTH;
   localparam logic [CNT_W-1:0] DCAP_V = CNT_W'(DCAP);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // byte store, one write and one registered read per cycle
   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // architectural state (always shows the state after the last accepted item)
   logic [AW-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic              done_ff, done_in;
   logic              err_ff, err_in;
   logic [TOT_W-1:0]  wtot_ff, wtot_in;
   logic [TOT_W-1:0]  rtot_ff, rtot_in;
   logic [CNT_W-1:0]  cap_ff;

   // run sequencer
   logic              state_ff, state_in;
   logic [AW-1:0]     run_addr_ff, run_addr_in;
   logic [RUN_W-1:0]  run_left_ff, run_left_in;

   // issue stage: one result per cycle while a queue slot is free, pushed into the queue in the cycle after issue
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_has_ff, s1_has_in;
   logic              s1_last_ff, s1_last_in;
   logic              s1_acc_ff, s1_acc_in;

   logic              mem_we;
   logic              rd_issue;
   logic              accept;
   logic              credit;
   logic              q_pop;
   logic              q_valid;
   logic [1:0]        q_count;
   logic [2:0]        q_occ;
   rsp_item_type      push_item;
   rsp_item_type      q_item;

   logic [CNT_W-1:0]  eff_cap;
   logic [CNT_W-1:0]  free_now;
   logic [RUN_W-1:0]  len_sat;
   logic [CNT_W-1:0]  len_w;
   logic              len_gt;
   logic [RUN_W-1:0]  peek_n;
   logic [AW-1:0]     wr_slot;
   logic [AW-1:0]     pop_slot;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CNT_W-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // status seen by every result: computed from the post-step state
   assign eff_cap  = (cap_ff > DCAP_V) ? DCAP_V : cap_ff;
   assign free_now = (held_ff >= eff_cap) ? '0 : (eff_cap - held_ff);

   assign len_sat  = (req_ch.run_length > MAX_RUN) ? MAX_RUN : req_ch.run_length;
   assign len_w    = CNT_W'(len_sat);
   assign len_gt   = (len_w > held_ff);
   assign peek_n   = len_gt ? held_ff[RUN_W-1:0] : len_sat;
   assign wr_slot  = slot_of(head_ff, held_ff);
   assign pop_slot = slot_of(head_ff, len_w);

   // queue space: entries held plus the one in flight, minus the one leaving now
   assign q_pop  = q_valid & rsp_ch.ready;
   assign q_occ  = 3'(q_count) + 3'(s1_valid_ff) - 3'(q_pop);
   assign credit = (q_occ < 3'd2);

   assign req_ch.ready = (state_ff == ST_IDLE) && credit;
   assign accept       = req_ch.valid && req_ch.ready;
   assign rd_issue     = (state_ff == ST_RUN) && credit;

   always_comb begin
      head_in     = head_ff;
      held_in     = held_ff;
      done_in     = done_ff;
      err_in      = err_ff;
      wtot_in     = wtot_ff;
      rtot_in     = rtot_ff;
      state_in    = state_ff;
      run_addr_in = run_addr_ff;
      run_left_in = run_left_ff;
      s1_valid_in = 1'b0;
      s1_has_in   = 1'b0;
      s1_last_in  = 1'b1;
      s1_acc_in   = 1'b0;
      mem_we      = 1'b0;

      if (accept) begin
         unique case (req_ch.mode)
            MODE_WRITE: begin
               s1_valid_in = 1'b1;
               if (free_now != '0) begin
                  mem_we    = 1'b1;
                  held_in   = held_ff + CNT_W'(1);
                  wtot_in   = wtot_ff + TOT_W'(1);
                  s1_acc_in = 1'b1;
               end
            end
            MODE_PEEK: begin
               if (peek_n != '0) begin
                  state_in    = ST_RUN;
                  run_addr_in = head_ff;
                  run_left_in = peek_n;
               end else begin
                  s1_valid_in = 1'b1;
               end
            end
            MODE_POP: begin
               s1_valid_in = 1'b1;
               if (len_gt) begin
                  err_in = 1'b1;
               end else begin
                  head_in = pop_slot;
                  held_in = held_ff - len_w;
                  rtot_in = rtot_ff + TOT_W'(len_sat);
               end
            end
            MODE_READ: begin
               if (len_gt) begin
                  err_in      = 1'b1;
                  s1_valid_in = 1'b1;
               end else if (len_sat == '0) begin
                  s1_valid_in = 1'b1;
               end else begin
                  // bytes are read from the old head; state moves on at once
                  state_in    = ST_RUN;
                  run_addr_in = head_ff;
                  run_left_in = len_sat;
                  head_in     = pop_slot;
                  held_in     = held_ff - len_w;
                  rtot_in     = rtot_ff + TOT_W'(len_sat);
               end
            end
            MODE_END: begin
               done_in     = 1'b1;
               s1_valid_in = 1'b1;
            end
            default: s1_valid_in = 1'b1;
         endcase
      end

      if (rd_issue) begin
         s1_valid_in = 1'b1;
         s1_has_in   = 1'b1;
         s1_last_in  = (run_left_ff == RUN_W'(1));
         run_left_in = run_left_ff - RUN_W'(1);
         run_addr_in = (run_addr_ff == AW'(DEPTH - 1)) ? '0 : (run_addr_ff + AW'(1));
         if (run_left_ff == RUN_W'(1)) begin
            state_in = ST_IDLE;
         end
      end
   end

   // store: writes happen only on accept, reads only during a run, so they never meet
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_slot] <= req_ch.data_byte;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[run_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      run_addr_ff <= run_addr_in;
      run_left_ff <= run_left_in;
      s1_has_ff   <= s1_has_in;
      s1_last_ff  <= s1_last_in;
      s1_acc_ff   <= s1_acc_in;
      if (reset) begin
         head_ff     <= '0;
         held_ff     <= '0;
         done_ff     <= 1'b0;
         err_ff      <= 1'b0;
         wtot_ff     <= '0;
         rtot_ff     <= '0;
         cap_ff      <= CAP_RESET;
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         held_ff     <= held_in;
         done_ff     <= done_in;
         err_ff      <= err_in;
         wtot_ff     <= wtot_in;
         rtot_ff     <= rtot_in;
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // result assembly: status comes straight from the state registers, which already
   // hold the post-step values in the cycle after the item was accepted
   always_comb begin
      push_item.out_byte      = s1_has_ff ? rd_data_ff : '0;
      push_item.has_byte      = s1_has_ff;
      push_item.last          = s1_last_ff;
      push_item.accepted      = s1_acc_ff;
      push_item.error_flag    = err_ff;
      push_item.ended         = done_ff;
      push_item.at_eof        = done_ff && (held_ff == '0);
      push_item.occupancy     = held_ff;
      push_item.free_space    = free_now;
      push_item.total_written = wtot_ff;
      push_item.total_read    = rtot_ff;
   end

   bbsf_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_item (push_item),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_item  (q_item),
      .count     (q_count)
   );

   assign rsp_ch.valid         = q_valid;
   assign rsp_ch.out_byte      = q_item.out_byte;
   assign rsp_ch.has_byte      = q_item.has_byte;
   assign rsp_ch.last          = q_item.last;
   assign rsp_ch.accepted      = q_item.accepted;
   assign rsp_ch.error_flag    = q_item.error_flag;
   assign rsp_ch.ended         = q_item.ended;
   assign rsp_ch.at_eof        = q_item.at_eof;
   assign rsp_ch.occupancy     = q_item.occupancy;
   assign rsp_ch.free_space    = q_item.free_space;
   assign rsp_ch.total_written = q_item.total_written;
   assign rsp_ch.total_read    = q_item.total_read;

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (run_left_ff != '0))
      else $error("run active with no bytes left");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (q_count != 2'd2 || q_pop))
      else $error("result pushed into a full queue");

   a_accept_makes_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN || s1_valid_ff))
      else $error("accepted item produced no result");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= DCAP_V)
      else $error("occupancy beyond store bound");

endmodule
